// ----- rtl/core/cdl_pkg.sv -----
package cdl_pkg;

  localparam int SITE_W = 10;
  localparam int KIND_W = 2;
  localparam int WORD_W = 32;
  localparam int CNT_W = 11;
  localparam int LEN_W = 11;
  localparam int RATE_W = 33;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W = 2;
  localparam int MAX_SITES_DEF = 1024;

  localparam logic [KIND_W-1:0] KIND_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_C = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic DIR_RIGHT = 1'b0;

  localparam logic [REG_IDX_W-1:0] REG_LEN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RATE_A = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATE_B = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RATE_C = 2'd3;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd9;
  localparam logic [RATE_W-1:0] RATE_RESET = 33'h1_0000_0000;

  typedef struct packed {
    logic              func;
    logic [SITE_W-1:0] site;
    logic [KIND_W-1:0] kind;
    logic              direction;
    logic [WORD_W-1:0] random_word;
  } cdl_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
    logic [CNT_W-1:0] count_c;
    logic             changed;
    logic             one_extinct;
    logic             fixated;
    logic             bad_index;
  } cdl_out_t;

  typedef struct packed {
    logic [LEN_W-1:0]           lattice_length;
    logic [2:0][RATE_W-1:0]     death_rate;
  } cdl_cfg_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic commit;
  } cdl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } cdl_sts_t;

  function automatic logic [KIND_W-1:0] prey_of(input logic [KIND_W-1:0] k);
    logic [KIND_W-1:0] r;
    unique case (k)
      KIND_A:  r = KIND_B;
      KIND_B:  r = KIND_C;
      KIND_C:  r = KIND_A;
      default: r = KIND_EMPTY;
    endcase
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] pred_of(input logic [KIND_W-1:0] k);
    logic [KIND_W-1:0] r;
    unique case (k)
      KIND_A:  r = KIND_C;
      KIND_B:  r = KIND_A;
      KIND_C:  r = KIND_B;
      default: r = KIND_EMPTY;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/cyclic_dominance_lattice_step_top.sv -----
// Ring lattice of three cyclically dominant species with per-species counts.
// Input words arrive on in_valid/in_ready with an in_data payload; each word
// either loads one site or runs one reaction step at a site. Every accepted
// word yields exactly one result word on out_valid/out_ready carrying the
// three counts and the changed, extinction, fixation and bad-index flags.
// Configuration registers sit on the APB port at byte addresses 0, 8, 16 and
// 24: lattice length and the death rates of species a, b and c.
// A word is taken while the site memory is read at the site and its neighbor;
// in the execute state, once the output register is free, the block does the
// read-modify-write, updates the counts and loads the output register. No new
// word is taken until the last one is committed, set by the single lattice
// memory and its read-modify-write.
// The result register frees the input side: a new word is accepted while a
// result still waits, and if the receiver is still stalling when that word
// finishes, the block holds it until the output register is taken.
// After reset the block sweeps the memory to empty, one site per cycle, with
// in_ready low over all MAX_SITES sites; configuration writes are still taken.
module cyclic_dominance_lattice_step_top
  import cdl_pkg::*;
#(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cdl_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cdl_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cdl_cfg_t cfg;
  cdl_cmd_t cmd;
  cdl_sts_t sts;

  cdl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cdl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdl_dp #(
    .MAX_SITES (MAX_SITES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/cdl_cfg.sv -----
module cdl_cfg
  import cdl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cdl_cfg_t              cfg
);

  logic [LEN_W-1:0]       len_r;
  logic [2:0][RATE_W-1:0] rate_r;
  logic [REG_IDX_W-1:0]   idx;
  logic                   wr_en;

  assign pready = 1'b1;
  assign idx = paddr[APB_ADDR_W-1:3];
  assign wr_en = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      rate_r <= {3{RATE_RESET}};
    end else if (wr_en) begin
      unique case (idx)
        REG_LEN:    len_r <= pwdata[LEN_W-1:0];
        REG_RATE_A: rate_r[0] <= pwdata[RATE_W-1:0];
        REG_RATE_B: rate_r[1] <= pwdata[RATE_W-1:0];
        REG_RATE_C: rate_r[2] <= pwdata[RATE_W-1:0];
        default:    len_r <= len_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEN:    prdata = APB_DATA_W'(len_r);
      REG_RATE_A: prdata = APB_DATA_W'(rate_r[0]);
      REG_RATE_B: prdata = APB_DATA_W'(rate_r[1]);
      REG_RATE_C: prdata = APB_DATA_W'(rate_r[2]);
      default:    prdata = '0;
    endcase
  end

  assign cfg.lattice_length = len_r;
  assign cfg.death_rate = rate_r;

endmodule

// ----- rtl/core/cdl_ctrl.sv -----
module cdl_ctrl
  import cdl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cdl_sts_t sts,
  output cdl_cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/cdl_dp.sv -----
module cdl_dp
  import cdl_pkg::*;
#(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cdl_cfg_t cfg,
  input  cdl_cmd_t cmd,
  output cdl_sts_t sts,
  input  cdl_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output cdl_out_t out_data
);

  localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SITES - 1);

  logic [KIND_W-1:0] mem [MAX_SITES];

  logic [AW-1:0]          clr_cnt_r;
  logic [LEN_W-1:0]       len_eff;
  logic [LEN_W-1:0]       site_ext;
  logic [LEN_W-1:0]       right_nb;
  logic [LEN_W-1:0]       nb_in;
  logic                   bad_in;

  logic                   func_r;
  logic [KIND_W-1:0]      kind_r;
  logic [WORD_W-1:0]      u_r;
  logic                   bad_r;
  logic [AW-1:0]          site_a_r;
  logic [AW-1:0]          nb_a_r;
  logic [KIND_W-1:0]      me_r;
  logic [KIND_W-1:0]      other_r;

  logic [2:0][CNT_W-1:0]  cnt_r;
  logic [2:0][CNT_W-1:0]  cnt_nxt;
  logic                   out_valid_r;
  cdl_out_t               out_r;

  logic [KIND_W-1:0]      prey;
  logic [KIND_W-1:0]      pred;
  logic [KIND_W-1:0]      dec_k;
  logic [KIND_W-1:0]      inc_k;
  logic                   exec_we;
  logic [AW-1:0]          exec_waddr;
  logic [KIND_W-1:0]      exec_wdata;
  logic                   changed;
  logic                   extinct;
  logic                   fix;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [KIND_W-1:0]      wdata;

  function automatic logic [CNT_W-1:0] cnt_sel(input logic [2:0][CNT_W-1:0] c,
                                               input logic [KIND_W-1:0] k);
    logic [CNT_W-1:0] r;
    unique case (k)
      KIND_A:  r = c[0];
      KIND_B:  r = c[1];
      KIND_C:  r = c[2];
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [RATE_W-1:0] rate_sel(input logic [2:0][RATE_W-1:0] c,
                                                 input logic [KIND_W-1:0] k);
    logic [RATE_W-1:0] r;
    unique case (k)
      KIND_A:  r = c[0];
      KIND_B:  r = c[1];
      KIND_C:  r = c[2];
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    if (32'(cfg.lattice_length) > 32'(MAX_SITES)) begin
      len_eff = LEN_W'(MAX_SITES);
    end else begin
      len_eff = cfg.lattice_length;
    end
  end

  assign site_ext = LEN_W'(in_data.site);
  assign bad_in = site_ext >= len_eff;
  assign right_nb = site_ext + LEN_W'(1);

  always_comb begin
    if (in_data.direction == DIR_RIGHT) begin
      nb_in = (right_nb >= len_eff) ? '0 : right_nb;
    end else begin
      nb_in = (site_ext == '0) ? len_eff - LEN_W'(1) : site_ext - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_data.func;
      kind_r <= in_data.kind;
      u_r <= in_data.random_word;
      bad_r <= bad_in;
      site_a_r <= AW'(in_data.site);
      nb_a_r <= AW'(nb_in);
    end
  end

  assign prey = prey_of(me_r);
  assign pred = pred_of(me_r);

  always_comb begin
    exec_we = 1'b0;
    exec_waddr = site_a_r;
    exec_wdata = kind_r;
    dec_k = KIND_EMPTY;
    inc_k = KIND_EMPTY;
    changed = 1'b0;
    if (!bad_r) begin
      if (func_r == FUNC_LOAD) begin
        exec_we = 1'b1;
        dec_k = me_r;
        inc_k = kind_r;
      end else if (me_r != KIND_EMPTY) begin
        if (other_r == prey) begin
          if (cnt_sel(cnt_r, prey) != '0 &&
              {1'b0, u_r} < rate_sel(cfg.death_rate, prey)) begin
            exec_we = 1'b1;
            exec_waddr = nb_a_r;
            exec_wdata = me_r;
            dec_k = prey;
            inc_k = me_r;
            changed = 1'b1;
          end
        end else if (other_r == pred) begin
          if (cnt_sel(cnt_r, me_r) != '0 &&
              {1'b0, u_r} < rate_sel(cfg.death_rate, me_r)) begin
            exec_we = 1'b1;
            exec_waddr = site_a_r;
            exec_wdata = pred;
            dec_k = me_r;
            inc_k = pred;
            changed = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    extinct = 1'b0;
    fix = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (dec_k == KIND_W'(k) && cnt_nxt[k] != '0) begin
        cnt_nxt[k] = cnt_nxt[k] - CNT_W'(1);
      end
      if (inc_k == KIND_W'(k)) begin
        cnt_nxt[k] = cnt_nxt[k] + CNT_W'(1);
      end
      if (cnt_nxt[k] == '0) begin
        extinct = 1'b1;
      end
      if (cnt_nxt[k] == len_eff) begin
        fix = 1'b1;
      end
    end
  end

  assign we = cmd.clr_step | (cmd.commit & exec_we);
  assign waddr = cmd.clr_step ? clr_cnt_r : exec_waddr;
  assign wdata = cmd.clr_step ? KIND_EMPTY : exec_wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.accept) begin
      me_r <= mem[AW'(in_data.site)];
      other_r <= mem[AW'(nb_in)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        cnt_r <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.count_a <= cnt_nxt[0];
      out_r.count_b <= cnt_nxt[1];
      out_r.count_c <= cnt_nxt[2];
      out_r.changed <= changed;
      out_r.one_extinct <= extinct;
      out_r.fixated <= fix;
      out_r.bad_index <= bad_r;
    end
  end

  assign sts.clr_last = clr_cnt_r == LAST_ADDR;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
